// ===== sv/dq_pkg.sv =====
// shared constants, codes and types of the double-ended queue
package dq_pkg;

	localparam int DEPTH       = 256;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam int DATA_W      = 32;
	localparam int MODE_W      = 2;
	localparam int STAT_W      = 2;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 48;
	// read-out tree reduces four nodes per level
	localparam int TREE_LVLS   = (IDX_W + 1) / 2;
	localparam int TREE_LEAVES = 1 << (2 * TREE_LVLS);
	localparam int WAIT_W      = (TREE_LVLS > 1) ? $clog2(TREE_LVLS) : 1;

	typedef enum logic [MODE_W-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_BUSY,
		S_HOLD
	} state_t;

	typedef struct packed {
		logic shift_right;
		logic shift_left;
		logic load;
		logic rd_sel;
	} cell_cmd_t;

endpackage

// ===== sv/dq_cell.sv =====
// one storage cell of the queue chain
module dq_cell (
	input  logic                      clk,
	input  dq_pkg::cell_cmd_t         cmd,
	input  logic [dq_pkg::DATA_W-1:0] push_value,
	input  logic [dq_pkg::DATA_W-1:0] left_data,
	input  logic [dq_pkg::DATA_W-1:0] right_data,
	output logic [dq_pkg::DATA_W-1:0] data,
	output logic [dq_pkg::DATA_W-1:0] rd_data
);

	logic [dq_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (cmd.shift_right) begin
			data_q <= left_data;
		end else if (cmd.shift_left) begin
			data_q <= right_data;
		end else if (cmd.load) begin
			data_q <= push_value;
		end
	end

	assign data    = data_q;
	assign rd_data = cmd.rd_sel ? data_q : '0;

endmodule

// ===== sv/dq_tree.sv =====
// registered or-tree that collects the selected cell value
module dq_tree (
	input  logic                                         clk,
	input  logic [dq_pkg::DEPTH-1:0][dq_pkg::DATA_W-1:0] leaf,
	output logic [dq_pkg::DATA_W-1:0]                    root
);

	logic [dq_pkg::DATA_W-1:0] leaf_pad [dq_pkg::TREE_LEAVES];
	logic [dq_pkg::DATA_W-1:0] lvl_q    [1:dq_pkg::TREE_LVLS][dq_pkg::TREE_LEAVES/4];

	genvar j, l;

	generate
		for (j = 0; j < dq_pkg::TREE_LEAVES; j++) begin : g_leaf
			if (j < dq_pkg::DEPTH) begin : g_used
				assign leaf_pad[j] = leaf[j];
			end else begin : g_pad
				assign leaf_pad[j] = '0;
			end
		end

		for (l = 1; l <= dq_pkg::TREE_LVLS; l++) begin : g_lvl
			localparam int NODES = dq_pkg::TREE_LEAVES >> (2 * l);
			for (j = 0; j < NODES; j++) begin : g_node
				if (l == 1) begin : g_first
					always_ff @(posedge clk) begin
						lvl_q[l][j] <= leaf_pad[4*j] | leaf_pad[4*j+1]
							| leaf_pad[4*j+2] | leaf_pad[4*j+3];
					end
				end else begin : g_upper
					always_ff @(posedge clk) begin
						lvl_q[l][j] <= lvl_q[l-1][4*j] | lvl_q[l-1][4*j+1]
							| lvl_q[l-1][4*j+2] | lvl_q[l-1][4*j+3];
					end
				end
			end
		end
	endgenerate

	assign root = lvl_q[dq_pkg::TREE_LVLS][0];

endmodule

// ===== sv/double_ended_queue.sv =====
// bounded deque as a chain of shifting cells, front value always in cell 0
// result path: the selected cell value passes the levels of the registered 4-to-1
//   read-out tree behind the cells and is then captured in the output register
// flow: no new input is taken while a result is pending; the next input is taken in the
//   cycle the pending result transfers
// reset: entry count and control cleared at once; cell contents undefined until pushed
module double_ended_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// mode [1:0], push_value [33:2], zero fill [39:34]
	input  logic [dq_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// popped_value [31:0], status [33:32], entry_count [42:34], zero fill [47:43]
	output logic [dq_pkg::M_TDATA_W-1:0] m_tdata
);

	dq_pkg::state_t  state_q, state_d;
	logic [dq_pkg::WAIT_W-1:0] wait_q;
	logic [dq_pkg::CNT_W-1:0]  count_q, count_d;
	dq_pkg::status_t res_status_q, status_d;
	logic [dq_pkg::CNT_W-1:0]  res_count_q;
	logic [dq_pkg::DATA_W-1:0] out_value_q;

	dq_pkg::op_t               op;
	logic [dq_pkg::DATA_W-1:0] push_value;
	logic                      accept, full, empty, is_push, ok, capture, tree_done;
	logic                      do_push_front, do_push_back, do_pop_front;

	dq_pkg::cell_cmd_t cell_cmd [dq_pkg::DEPTH];
	logic [dq_pkg::DEPTH-1:0][dq_pkg::DATA_W-1:0] cell_data;
	logic [dq_pkg::DEPTH-1:0][dq_pkg::DATA_W-1:0] rd_data;
	logic [dq_pkg::DATA_W-1:0] tree_root;

	assign op         = dq_pkg::op_t'(s_tdata[dq_pkg::MODE_W-1:0]);
	assign push_value = s_tdata[dq_pkg::MODE_W +: dq_pkg::DATA_W];
	assign accept     = s_tvalid & s_tready;

	assign full    = (count_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
	assign empty   = (count_q == '0);
	assign is_push = (op == dq_pkg::OP_PUSH_FRONT) || (op == dq_pkg::OP_PUSH_BACK);
	assign ok      = is_push ? !full : !empty;

	assign do_push_front = accept && ok && (op == dq_pkg::OP_PUSH_FRONT);
	assign do_push_back  = accept && ok && (op == dq_pkg::OP_PUSH_BACK);
	assign do_pop_front  = accept && ok && (op == dq_pkg::OP_POP_FRONT);

	always_comb begin
		count_d  = count_q;
		status_d = dq_pkg::STAT_OK;
		if (!ok) begin
			status_d = is_push ? dq_pkg::STAT_FULL : dq_pkg::STAT_EMPTY;
		end else if (is_push) begin
			count_d = count_q + 1'b1;
		end else begin
			count_d = count_q - 1'b1;
		end
	end

	genvar i;
	generate
		for (i = 0; i < dq_pkg::DEPTH; i++) begin : g_cell
			logic [dq_pkg::DATA_W-1:0] left_data, right_data;

			assign cell_cmd[i] = '{
				shift_right: do_push_front,
				shift_left:  do_pop_front,
				load:        do_push_back && (count_q == dq_pkg::CNT_W'(i)),
				rd_sel:      ok && (((op == dq_pkg::OP_POP_FRONT) && (i == 0))
					|| ((op == dq_pkg::OP_POP_BACK) && (count_q == dq_pkg::CNT_W'(i + 1))))
			};

			if (i == 0) begin : g_head
				assign left_data = push_value;
			end else begin : g_left
				assign left_data = cell_data[i-1];
			end

			if (i == dq_pkg::DEPTH - 1) begin : g_tail
				assign right_data = cell_data[i];
			end else begin : g_right
				assign right_data = cell_data[i+1];
			end

			dq_cell u_cell (
				.clk        (clk),
				.cmd        (cell_cmd[i]),
				.push_value (push_value),
				.left_data  (left_data),
				.right_data (right_data),
				.data       (cell_data[i]),
				.rd_data    (rd_data[i])
			);
		end
	endgenerate

	dq_tree u_tree (
		.clk  (clk),
		.leaf (rd_data),
		.root (tree_root)
	);

	assign tree_done = (wait_q == dq_pkg::WAIT_W'(dq_pkg::TREE_LVLS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dq_pkg::S_IDLE: begin
				if (s_tvalid) state_d = dq_pkg::S_BUSY;
			end
			dq_pkg::S_BUSY: begin
				if (tree_done) state_d = dq_pkg::S_HOLD;
			end
			dq_pkg::S_HOLD: begin
				if (m_tready) state_d = s_tvalid ? dq_pkg::S_BUSY : dq_pkg::S_IDLE;
			end
			default: state_d = dq_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		capture  = 1'b0;
		unique case (state_q)
			dq_pkg::S_IDLE: s_tready = 1'b1;
			dq_pkg::S_BUSY: capture  = tree_done;
			dq_pkg::S_HOLD: begin
				m_tvalid = 1'b1;
				s_tready = m_tready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dq_pkg::S_IDLE;
			wait_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				wait_q  <= '0;
				count_q <= count_d;
			end else if (state_q == dq_pkg::S_BUSY) begin
				wait_q <= wait_q + 1'b1;
			end
		end
	end

	// status and count are held from the transfer until the result leaves
	always_ff @(posedge clk) begin
		if (accept) begin
			res_status_q <= status_d;
			res_count_q  <= count_d;
		end
		if (capture) begin
			out_value_q <= tree_root;
		end
	end

	assign m_tdata = {
		(dq_pkg::M_TDATA_W - dq_pkg::DATA_W - dq_pkg::STAT_W - dq_pkg::CNT_W)'(0),
		res_count_q,
		res_status_q,
		out_value_q
	};

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
		else $error("entry count beyond capacity");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (res_status_q == dq_pkg::STAT_EMPTY)) |-> (out_value_q == '0))
		else $error("pop on empty returned a value");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push_front || do_push_back) |=> (count_q == $past(count_q) + 1'b1))
		else $error("push did not grow the queue");
`endif

endmodule
